### sv/oul_pkg.sv
`default_nettype none

package oul_pkg;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_REMOVE  = 2'd1;
  localparam logic [1:0] OP_REM_POS = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] key;
    logic [3:0]  position;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] count;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // latch the request and rewind the scan
    logic step;      // read the next entry and compare or move the previous one
    logic wr;        // with step: write the previous read one place lower
    logic seek;      // restart the read pointer just past the entry to delete
    logic seek_pos;  // with seek: take the request position, else the hit index
    logic append;    // write the key at the end and count up
    logic dec;       // count down after a delete
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] command;
    logic       hit;
    logic       done;
    logic       full;
    logic       pos_ok;
    logic [4:0] count;
  } dp_sts_t;

endpackage

`default_nettype wire

### sv/oul_dp.sv
`default_nettype none

module oul_dp #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire oul_pkg::req_t   req,
  input  wire oul_pkg::dp_cmd_t cmd,
  output oul_pkg::dp_sts_t     sts
);
  import oul_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [KEY_BITS-1:0] mem [CAPACITY];

  logic [1:0]          command;
  logic [KEY_BITS-1:0] key;
  logic [3:0]          position;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    rd_idx;
  logic                rd_valid;
  logic [KEY_BITS-1:0] rdata;

  logic                idx_lt;
  logic                wr_en;
  logic [IDX_W-1:0]    waddr;
  logic [KEY_BITS-1:0] wdata;
  logic [CNT_W-1:0]    seek_base;
  logic [CNT_W-1:0]    rd_idx_m1;

  assign idx_lt    = idx < count;
  assign rd_idx_m1 = rd_idx - CNT_W'(1);
  assign seek_base = cmd.seek_pos ? CNT_W'(position) : rd_idx;

  assign wr_en = cmd.append | (cmd.step & cmd.wr & rd_valid);
  assign waddr = cmd.append ? count[IDX_W-1:0] : rd_idx_m1[IDX_W-1:0];
  assign wdata = cmd.append ? key : rdata;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      command  <= req.command;
      key      <= KEY_BITS'(req.key);
      position <= req.position;
    end
    if (cmd.step && idx_lt) begin
      rdata  <= mem[idx[IDX_W-1:0]];
      rd_idx <= idx;
    end
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      idx      <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        idx      <= '0;
        rd_valid <= 1'b0;
      end else if (cmd.seek) begin
        idx      <= seek_base + CNT_W'(1);
        rd_valid <= 1'b0;
      end else if (cmd.step) begin
        rd_valid <= idx_lt;
        if (idx_lt) begin
          idx <= idx + CNT_W'(1);
        end
      end
      if (cmd.append) begin
        count <= count + CNT_W'(1);
      end else if (cmd.dec) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_comb begin
    sts.command = command;
    sts.hit     = rd_valid && (rdata == key);
    // The scan or shift is over once no read is pending and none is left to issue.
    sts.done    = !rd_valid && !idx_lt;
    sts.full    = count >= CAP_CNT;
    sts.pos_ok  = CMP_W'(position) < CMP_W'(count);
    sts.count   = 5'(count);
  end

endmodule

`default_nettype wire

### sv/oul_ctrl.sv
`default_nettype none

module oul_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output oul_pkg::rsp_t         rsp,
  input  wire oul_pkg::dp_sts_t sts,
  output oul_pkg::dp_cmd_t      cmd
);
  import oul_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t     state;
  logic [2:0] status;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.start = req_valid;
      end
      S_SCAN: begin
        case (sts.command)
          OP_INSERT: begin
            if (!sts.hit) begin
              if (sts.done) begin
                cmd.append = !sts.full;
              end else begin
                cmd.step = 1'b1;
              end
            end
          end
          OP_REMOVE: begin
            if (sts.hit) begin
              cmd.seek = 1'b1;
            end else if (!sts.done) begin
              cmd.step = 1'b1;
            end
          end
          OP_REM_POS: begin
            cmd.seek     = sts.pos_ok;
            cmd.seek_pos = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_SHIFT: begin
        if (sts.done) begin
          cmd.dec = 1'b1;
        end else begin
          cmd.step = 1'b1;
          cmd.wr   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      status    <= ST_OK;
      rsp_valid <= 1'b0;
    end else begin
      // In the final state the response register is handled below.
      if (rsp_valid && !rsp_stall && state != S_FINISH) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          case (sts.command)
            OP_INSERT: begin
              if (sts.hit) begin
                status <= ST_DUP;
                state  <= S_FINISH;
              end else if (sts.done) begin
                status <= sts.full ? ST_FULL : ST_OK;
                state  <= S_FINISH;
              end
            end
            OP_REMOVE: begin
              if (sts.hit) begin
                state <= S_SHIFT;
              end else if (sts.done) begin
                status <= ST_NOTFOUND;
                state  <= S_FINISH;
              end
            end
            OP_REM_POS: begin
              if (sts.pos_ok) begin
                state <= S_SHIFT;
              end else begin
                status <= ST_BADPOS;
                state  <= S_FINISH;
              end
            end
            default: begin
              status <= ST_OK;
              state  <= S_FINISH;
            end
          endcase
        end
        S_SHIFT: begin
          if (sts.done) begin
            status <= ST_OK;
            state  <= S_FINISH;
          end
        end
        S_FINISH: begin
          // The count has settled by now, so the beat carries the updated value.
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid  <= 1'b1;
            rsp.status <= status;
            rsp.count  <= sts.count;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/ordered_unique_list_top.sv
`default_nettype none

// Ordered list of distinct keys with a live count, held in a single-port-write,
// registered-read memory of CAPACITY entries. One request is worked at a time and
// each gives exactly one response beat. A request walks the memory one entry per
// cycle. A remove by value stops its scan at the match and the shift carries on
// from there, so both together visit each entry once. The key scan and the shift
// share the single read port. A response waiting in the output register does not
// block acceptance of the next request; that request holds in its last state until
// the register frees. Keys are taken modulo 2^KEY_BITS; an insert of a new key into
// a full list answers with the full status.
module ordered_unique_list_top #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire oul_pkg::req_t  req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output oul_pkg::rsp_t       rsp
);
  import oul_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  oul_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .sts       (sts),
    .cmd       (cmd)
  );

  oul_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

`default_nettype wire

### sv/oul_checker.sv
`default_nettype none

module oul_checker #(
  parameter int CAPACITY = 16
) (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_stall,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire oul_pkg::rsp_t rsp
);
  import oul_pkg::*;

  localparam logic [4:0] CAP_MOD = 5'(CAPACITY);

  // A stalled response beat holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response beat changed while stalled");

  // A full refusal reports a list that is at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |-> rsp.count == CAP_MOD)
    else $error("full status with a count below capacity");

  // A duplicate can only be found in a list that holds something.
  a_dup_nonempty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_DUP) |-> (rsp.count != 5'd0 || CAPACITY >= 32))
    else $error("duplicate status with an empty list");

  // No response beat comes out of reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // The block takes a request only while it is idle, so acceptance is followed by stall.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken while one is in progress");

endmodule

bind ordered_unique_list_top oul_checker #(.CAPACITY(CAPACITY)) u_oul_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

### test/tb_ordered_unique_list_top.sv
`timescale 1ns / 100ps

module tb_ordered_unique_list_top;
  import oul_pkg::*;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 32;
  localparam logic [31:0] KEY_MASK =
    (KEY_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << KEY_BITS) - 32'd1);
  localparam int RANDOM_ITEMS = 1250;
  localparam int POOL_SIZE = 24;
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 32;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    req_t beat;
    bit   hold_for_drain;
  } queued_req_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_SOLID} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  ordered_unique_list_top #(
    .CAPACITY(CAPACITY),
    .KEY_BITS(KEY_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  queued_req_t req_queue[$];
  rsp_t        pending_rsp[$];
  logic [31:0] list_keys[CAPACITY];
  int unsigned list_count = 0;
  logic [31:0] key_pool[POOL_SIZE];
  int          mismatches = 0;
  int unsigned cycle_count = 0;
  bit          req_taken = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one request to the shadow list and returns the response it should produce.
  function automatic rsp_t apply_request(req_t r);
    logic [31:0] k;
    int unsigned hit_idx;
    int unsigned drop_idx;
    bit          do_drop;
    rsp_t        res;
    k = r.key & KEY_MASK;
    hit_idx = list_count;
    drop_idx = 0;
    do_drop = 1'b0;
    res.status = ST_OK;
    for (int unsigned i = 0; i < list_count; i++) begin
      if (hit_idx == list_count && list_keys[i] == k) hit_idx = i;
    end
    case (r.command)
      OP_INSERT: begin
        // A duplicate is reported even when the list is full.
        if (hit_idx < list_count) res.status = ST_DUP;
        else if (list_count >= CAPACITY) res.status = ST_FULL;
        else begin
          list_keys[list_count] = k;
          list_count++;
        end
      end
      OP_REMOVE: begin
        if (hit_idx < list_count) begin
          drop_idx = hit_idx;
          do_drop = 1'b1;
        end else res.status = ST_NOTFOUND;
      end
      OP_REM_POS: begin
        if (32'(r.position) < list_count) begin
          drop_idx = 32'(r.position);
          do_drop = 1'b1;
        end else res.status = ST_BADPOS;
      end
      OP_NONE: begin
        // The unused command leaves the list alone and answers ok.
      end
      default: begin
      end
    endcase
    if (do_drop) begin
      for (int unsigned j = drop_idx; j + 1 < list_count; j++) list_keys[j] = list_keys[j + 1];
      list_count--;
    end
    res.count = 5'(list_count);
    return res;
  endfunction

  task automatic push_req(logic [1:0] cmd, logic [31:0] k, logic [3:0] pos, bit drain);
    queued_req_t item;
    item.beat.command = cmd;
    item.beat.key = k;
    item.beat.position = pos;
    item.hold_for_drain = drain;
    req_queue.push_back(item);
  endtask

  task automatic note_mismatch(string what, int want, int got);
    mismatches++;
    $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
  endtask

  // Sender: bursts of beats separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (req_queue.size() == 0 ||
                   (req_queue[0].hold_for_drain && pending_rsp.size() != 0)) begin
        req_valid <= 1'b0;
      end else begin
        req <= req_queue[0].beat;
        req_valid <= 1'b1;
        void'(req_queue.pop_front());
        if (burst_left > 1) burst_left--;
        else begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
        end
      end
    end
  end

  // Receiver: stall pattern switches between free running, random and solid stretches.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_left = (stall_mode == STALL_SOLID) ? $urandom_range(1, 30) : $urandom_range(10, 80);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE: rsp_stall <= 1'b0;
      STALL_RANDOM: rsp_stall <= 1'($urandom_range(0, 1));
      default: rsp_stall <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      // Check the response first so that a beat accepted on this edge cannot match it.
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          note_mismatch("unexpected response beat, pending count", 0, 1);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.status !== want.status) note_mismatch("status", want.status, rsp.status);
          if (rsp.count !== want.count) note_mismatch("count", want.count, rsp.count);
        end
      end
      req_taken <= req_valid && !req_stall;
      if (req_valid && !req_stall) pending_rsp.push_back(apply_request(req));
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d responses outstanding", $time, pending_rsp.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    bit          filling;
    int unsigned phase_left;
    int unsigned roll;
    logic [1:0]  cmd;
    logic [31:0] k;
    logic [3:0]  pos;
    filling = 1'b0;
    phase_left = 0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;

    // Empty list: a remove by value, a remove by position and the unused command.
    push_req(OP_REMOVE, 32'h1234_5678, 4'd0, 1'b0);
    push_req(OP_REM_POS, 32'h0, 4'd0, 1'b0);
    push_req(OP_NONE, 32'hFFFF_FFFF, 4'd15, 1'b0);
    // Extreme keys and a duplicate.
    push_req(OP_INSERT, 32'h0000_0000, 4'd0, 1'b0);
    push_req(OP_INSERT, 32'hFFFF_FFFF, 4'd15, 1'b0);
    push_req(OP_INSERT, 32'h0000_0000, 4'd0, 1'b0);
    // Fill to capacity, then a new key and a duplicate against the full list.
    for (int i = 1; i <= CAPACITY - 2; i++) push_req(OP_INSERT, 32'(i) * 32'h0101_0101, 4'd0, 1'b0);
    push_req(OP_INSERT, 32'hA5A5_5A5A, 4'd0, 1'b0);
    push_req(OP_INSERT, 32'hFFFF_FFFF, 4'd0, 1'b0);
    // Remove the last and the first entry, one by value, then a position past the end.
    push_req(OP_REM_POS, 32'h0, 4'd15, 1'b0);
    push_req(OP_REM_POS, 32'h0, 4'd0, 1'b0);
    push_req(OP_REMOVE, 32'hFFFF_FFFF, 4'd0, 1'b0);
    push_req(OP_REM_POS, 32'h0, 4'd15, 1'b0);

    // Random part alternates between filling and draining phases over a small key pool.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        filling = !filling;
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3) cmd = OP_NONE;
      else if (filling) cmd = (roll < 72) ? OP_INSERT : (roll < 86) ? OP_REMOVE : OP_REM_POS;
      else cmd = (roll < 22) ? OP_INSERT : (roll < 60) ? OP_REMOVE : OP_REM_POS;
      k = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
      pos = ($urandom_range(0, 9) < 6) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(0, 15));
      push_req(cmd, k, pos, (n % 300) == 0);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_queue.size() != 0 || req_valid) @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
